// ----- hw/rtl/tun_pkg.sv -----
// Shared constants and width helpers for the triangle unit normal pipeline.
package tun_pkg;

	// vector components per vertex and per normal
	localparam int unsigned LANES = 3;

	// magnitude of one cross-product component
	function automatic int mag_width(input int cw);
		return 2 * cw + 1;
	endfunction

	// square of one magnitude
	function automatic int sq_width(input int cw);
		return 2 * mag_width(cw);
	endfunction

	// sum of the three squares
	function automatic int len_width(input int cw);
		return sq_width(cw) + 2;
	endfunction

endpackage

// ----- hw/rtl/tun_cross.sv -----
// Edge vectors, cross product and per-component sign and magnitude, three stages.
module tun_cross #(
	parameter int CW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [CW-1:0]                v0 [tun_pkg::LANES],
	input  logic signed [CW-1:0]                v1 [tun_pkg::LANES],
	input  logic signed [CW-1:0]                v2 [tun_pkg::LANES],
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tun_pkg::mag_width(CW)-1:0]   mag [tun_pkg::LANES],
	output logic                                pos [tun_pkg::LANES]
);
	import tun_pkg::*;

	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int MW = mag_width(CW);
	localparam int NS = 3;

	logic [NS-1:0] v_q;
	logic [NS:0]   en;

	logic signed [DW-1:0] e1_s1 [LANES];
	logic signed [DW-1:0] e2_s1 [LANES];
	logic signed [PW-1:0] pa_s2 [LANES];
	logic signed [PW-1:0] pb_s2 [LANES];
	logic [MW-1:0]        mag_s3 [LANES];
	logic                 pos_s3 [LANES];

	// a stage advances when it is empty or the next one advances
	assign en[NS] = out_ready;
	for (genvar i = 0; i < NS; i++) begin : g_en
		assign en[i] = !v_q[i] || en[i+1];
	end
	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		localparam int K1 = (k + 1) % LANES;
		localparam int K2 = (k + 2) % LANES;
		logic signed [PW:0] c;

		assign c = (PW+1)'(pa_s2[k]) - (PW+1)'(pb_s2[k]);

		always_ff @(posedge clk) begin
			if (en[0]) begin
				e1_s1[k] <= DW'(v1[k]) - DW'(v0[k]);
				e2_s1[k] <= DW'(v2[k]) - DW'(v0[k]);
			end
			if (en[1]) begin
				pa_s2[k] <= e1_s1[K1] * e2_s1[K2];
				pb_s2[k] <= e1_s1[K2] * e2_s1[K1];
			end
			if (en[2]) begin
				mag_s3[k] <= c[PW] ? MW'(-c) : MW'(c);
				pos_s3[k] <= !c[PW] && (c != '0);
			end
		end

		assign mag[k] = mag_s3[k];
		assign pos[k] = pos_s3[k];
	end

endmodule

// ----- hw/rtl/tun_square.sv -----
// Squares of the magnitudes from split partial products and their sum, three stages.
module tun_square #(
	parameter int CW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tun_pkg::mag_width(CW)-1:0]   mag [tun_pkg::LANES],
	input  logic                                pos_in [tun_pkg::LANES],
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tun_pkg::sq_width(CW)-1:0]    sq [tun_pkg::LANES],
	output logic [tun_pkg::len_width(CW)-1:0]   len,
	output logic                                pos [tun_pkg::LANES],
	output logic                                zero
);
	import tun_pkg::*;

	localparam int MW  = mag_width(CW);
	localparam int HW  = (MW + 1) / 2;
	localparam int MHW = MW - HW;
	localparam int SQW = sq_width(CW);
	localparam int LW  = len_width(CW);
	localparam int NS  = 3;

	logic [NS-1:0] v_q;
	logic [NS:0]   en;

	logic [2*HW-1:0]  ll_s1 [LANES];
	logic [2*MHW-1:0] hh_s1 [LANES];
	logic [MW-1:0]    lh_s1 [LANES];
	logic             pos_s1 [LANES];
	logic             zero_s1;
	logic [SQW-1:0]   sq_s2 [LANES];
	logic             pos_s2 [LANES];
	logic             zero_s2;
	logic [SQW-1:0]   sq_s3 [LANES];
	logic [LW-1:0]    len_s3;
	logic             pos_s3 [LANES];
	logic             zero_s3;

	assign en[NS] = out_ready;
	for (genvar i = 0; i < NS; i++) begin : g_en
		assign en[i] = !v_q[i] || en[i+1];
	end
	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic [HW-1:0]  ml;
		logic [MHW-1:0] mh;

		assign ml = mag[k][HW-1:0];
		assign mh = mag[k][MW-1:HW];

		always_ff @(posedge clk) begin
			if (en[0]) begin
				ll_s1[k]  <= (2*HW)'(ml) * (2*HW)'(ml);
				hh_s1[k]  <= (2*MHW)'(mh) * (2*MHW)'(mh);
				lh_s1[k]  <= MW'(mh) * MW'(ml);
				pos_s1[k] <= pos_in[k];
			end
			if (en[1]) begin
				sq_s2[k]  <= (SQW'(hh_s1[k]) << (2 * HW)) + (SQW'(lh_s1[k]) << (HW + 1))
					+ SQW'(ll_s1[k]);
				pos_s2[k] <= pos_s1[k];
			end
			if (en[2]) begin
				sq_s3[k]  <= sq_s2[k];
				pos_s3[k] <= pos_s2[k];
			end
		end

		assign sq[k]  = sq_s3[k];
		assign pos[k] = pos_s3[k];
	end

	always_ff @(posedge clk) begin
		if (en[0]) zero_s1 <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
		if (en[1]) zero_s2 <= zero_s1;
		if (en[2]) begin
			len_s3  <= LW'(sq_s2[0]) + LW'(sq_s2[1]) + LW'(sq_s2[2]);
			zero_s3 <= zero_s2;
		end
	end

	assign len  = len_s3;
	assign zero = zero_s3;

endmodule

// ----- hw/rtl/tun_quot.sv -----
// Scaled quotient, one bit per stage: largest q with q^2 * len <= sq * 2^(2F).
module tun_quot #(
	parameter int CW = 16,
	parameter int F  = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tun_pkg::sq_width(CW)-1:0]    sq [tun_pkg::LANES],
	input  logic [tun_pkg::len_width(CW)-1:0]   len,
	input  logic                                pos_in [tun_pkg::LANES],
	input  logic                                zero_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [F:0]                          quot [tun_pkg::LANES],
	output logic                                pos [tun_pkg::LANES],
	output logic                                zero
);
	import tun_pkg::*;

	localparam int LW = len_width(CW);
	localparam int TW = LW + 2 * F + 3;
	localparam int QW = F + 1;
	localparam int NS = F + 2;

	logic [NS-1:0] v_q;
	logic [NS:0]   en;

	// remainder of the right side, running q*len, partial quotient per lane
	logic [TW-1:0] rem_s [NS][LANES];
	logic [TW-1:0] acc_s [NS][LANES];
	logic [QW-1:0] quot_s [NS][LANES];
	logic          pos_s [NS][LANES];
	logic [LW-1:0] len_s [NS];
	logic          zero_s [NS];

	assign en[NS] = out_ready;
	for (genvar i = 0; i < NS; i++) begin : g_en
		assign en[i] = !v_q[i] || en[i+1];
	end
	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < LANES; k++) begin
				rem_s[0][k]  <= TW'(sq[k]) << (2 * F);
				acc_s[0][k]  <= '0;
				quot_s[0][k] <= '0;
				pos_s[0][k]  <= pos_in[k];
			end
			len_s[0]  <= len;
			zero_s[0] <= zero_in;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_bit
		localparam int B = F + 1 - j;
		for (genvar k = 0; k < LANES; k++) begin : g_lane
			logic [TW-1:0] trial;
			logic          take;

			// (q + 2^B)^2 * len - q^2 * len
			assign trial = (acc_s[j-1][k] << (B + 1)) + (TW'(len_s[j-1]) << (2 * B));
			assign take  = trial <= rem_s[j-1][k];

			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j][k]  <= take ? rem_s[j-1][k] - trial : rem_s[j-1][k];
					acc_s[j][k]  <= take ? acc_s[j-1][k] + (TW'(len_s[j-1]) << B)
						: acc_s[j-1][k];
					quot_s[j][k] <= take ? quot_s[j-1][k] | (QW'(1) << B) : quot_s[j-1][k];
					pos_s[j][k]  <= pos_s[j-1][k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				len_s[j]  <= len_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_out
		assign quot[k] = quot_s[NS-1][k];
		assign pos[k]  = pos_s[NS-1][k];
	end
	assign zero = zero_s[NS-1];

endmodule

// ----- hw/rtl/triangle_unit_normal.sv -----
// Top level of the triangle unit normal pipeline with its output register.
// Accepts one triangle per cycle unless a low norm_ready stalls the output;
// the quotient takes one pipeline stage per result bit.
// Each stage advances when empty or when the next one advances, so bubbles close up
// and a triangle is taken while a finished normal waits, as long as a stage is free.
// Reset clears all valid bits; data registers are not reset.
module triangle_unit_normal #(
	parameter int COORD_WIDTH = 16,
	parameter int NORMAL_FRAC = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tri_valid,
	output logic                            tri_ready,
	input  logic signed [COORD_WIDTH-1:0]   first_x,
	input  logic signed [COORD_WIDTH-1:0]   first_y,
	input  logic signed [COORD_WIDTH-1:0]   first_z,
	input  logic signed [COORD_WIDTH-1:0]   second_x,
	input  logic signed [COORD_WIDTH-1:0]   second_y,
	input  logic signed [COORD_WIDTH-1:0]   second_z,
	input  logic signed [COORD_WIDTH-1:0]   third_x,
	input  logic signed [COORD_WIDTH-1:0]   third_y,
	input  logic signed [COORD_WIDTH-1:0]   third_z,
	output logic                            norm_valid,
	input  logic                            norm_ready,
	output logic signed [NORMAL_FRAC+1:0]   normal_x,
	output logic signed [NORMAL_FRAC+1:0]   normal_y,
	output logic signed [NORMAL_FRAC+1:0]   normal_z,
	output logic                            degenerate
);
	import tun_pkg::*;

	localparam int MW  = mag_width(COORD_WIDTH);
	localparam int SQW = sq_width(COORD_WIDTH);
	localparam int LW  = len_width(COORD_WIDTH);
	localparam int OW  = NORMAL_FRAC + 2;
	localparam logic signed [OW-1:0] UNIT = OW'(2 ** NORMAL_FRAC);

	logic signed [COORD_WIDTH-1:0] v0 [LANES];
	logic signed [COORD_WIDTH-1:0] v1 [LANES];
	logic signed [COORD_WIDTH-1:0] v2 [LANES];

	assign v0 = '{first_x, first_y, first_z};
	assign v1 = '{second_x, second_y, second_z};
	assign v2 = '{third_x, third_y, third_z};

	// cross product stages
	logic          cr_valid, cr_ready;
	logic [MW-1:0] cr_mag [LANES];
	logic          cr_pos [LANES];

	tun_cross #(.CW(COORD_WIDTH)) u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tri_valid),
		.in_ready  (tri_ready),
		.v0        (v0),
		.v1        (v1),
		.v2        (v2),
		.out_valid (cr_valid),
		.out_ready (cr_ready),
		.mag       (cr_mag),
		.pos       (cr_pos)
	);

	// squared length stages
	logic           sq_valid, sq_ready;
	logic [SQW-1:0] sq_val [LANES];
	logic [LW-1:0]  sq_len;
	logic           sq_pos [LANES];
	logic           sq_zero;

	tun_square #(.CW(COORD_WIDTH)) u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cr_valid),
		.in_ready  (cr_ready),
		.mag       (cr_mag),
		.pos_in    (cr_pos),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.sq        (sq_val),
		.len       (sq_len),
		.pos       (sq_pos),
		.zero      (sq_zero)
	);

	// bit-per-stage quotient
	logic                 qt_valid, qt_ready;
	logic [NORMAL_FRAC:0] qt_quot [LANES];
	logic                 qt_pos [LANES];
	logic                 qt_zero;

	tun_quot #(.CW(COORD_WIDTH), .F(NORMAL_FRAC)) u_quot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.sq        (sq_val),
		.len       (sq_len),
		.pos_in    (sq_pos),
		.zero_in   (sq_zero),
		.out_valid (qt_valid),
		.out_ready (qt_ready),
		.quot      (qt_quot),
		.pos       (qt_pos),
		.zero      (qt_zero)
	);

	// output register: apply the negation, force zeros on a degenerate triangle
	logic                 out_valid_q;
	logic signed [OW-1:0] normal_q [LANES];
	logic                 degenerate_q;
	logic signed [OW-1:0] comp [LANES];

	assign qt_ready = !out_valid_q || norm_ready;

	for (genvar k = 0; k < LANES; k++) begin : g_comp
		// a positive cross component gives a negative normal component
		assign comp[k] = qt_zero ? '0
			: (qt_pos[k] ? -$signed(OW'(qt_quot[k])) : $signed(OW'(qt_quot[k])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (qt_ready) begin
			out_valid_q <= qt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (qt_ready) begin
			normal_q     <= comp;
			degenerate_q <= qt_zero;
		end
	end

	assign norm_valid = out_valid_q;
	assign normal_x   = normal_q[0];
	assign normal_y   = normal_q[1];
	assign normal_z   = normal_q[2];
	assign degenerate = degenerate_q;

	// a degenerate word carries a zero normal
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate word with nonzero normal");

	// every component stays within one unit
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |-> normal_x <= UNIT && normal_x >= -UNIT && normal_y <= UNIT
			&& normal_y >= -UNIT && normal_z <= UNIT && normal_z >= -UNIT)
		else $error("normal component out of range");

	// with the output register empty every stage can advance
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!norm_valid |-> tri_ready)
		else $error("input stalled with empty output");

	// a nondegenerate normal has at least one nonzero component
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
		else $error("nondegenerate word with zero normal");

endmodule

// ----- test/tun_checker.sv -----
// Checker for triangle_unit_normal: predicts each normal and compares the result words.
`timescale 1ns / 100ps
module tun_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tri_valid,
	input  logic               tri_ready,
	input  logic signed [15:0] first_x,
	input  logic signed [15:0] first_y,
	input  logic signed [15:0] first_z,
	input  logic signed [15:0] second_x,
	input  logic signed [15:0] second_y,
	input  logic signed [15:0] second_z,
	input  logic signed [15:0] third_x,
	input  logic signed [15:0] third_y,
	input  logic signed [15:0] third_z,
	input  logic               norm_valid,
	input  logic               norm_ready,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic               degenerate,
	output int                 fail_count,
	output int                 pending,
	output int                 normals_seen,
	output int                 flat_seen
);
	localparam int FRAC = 14;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               flat;
	} normal_t;

	normal_t normal_q[$];

	// largest q with q^2 * len2 <= m^2 * 2^(2*FRAC)
	function automatic logic [15:0] unit_mag(input logic [127:0] m, input logic [127:0] len2);
		logic [127:0] rhs;
		logic [127:0] cand;
		logic [127:0] q;
		rhs = (m * m) << (2 * FRAC);
		q = '0;
		for (int b = FRAC; b >= 0; b--) begin
			cand = q | (128'd1 << b);
			if (cand * cand * len2 <= rhs)
				q = cand;
		end
		return q[15:0];
	endfunction

	function automatic normal_t face_normal(input logic signed [15:0] v[9]);
		longint d1[3];
		longint d2[3];
		longint c[3];
		logic [127:0] m[3];
		logic [127:0] len2;
		logic [15:0] q;
		normal_t r;
		for (int k = 0; k < 3; k++) begin
			d1[k] = longint'(v[3 + k]) - longint'(v[k]);
			d2[k] = longint'(v[6 + k]) - longint'(v[k]);
		end
		c[0] = d1[1] * d2[2] - d1[2] * d2[1];
		c[1] = d1[2] * d2[0] - d1[0] * d2[2];
		c[2] = d1[0] * d2[1] - d1[1] * d2[0];
		len2 = '0;
		for (int k = 0; k < 3; k++) begin
			m[k] = (c[k] < 0) ? 128'(-c[k]) : 128'(c[k]);
			len2 += m[k] * m[k];
		end
		r = '0;
		if (len2 == 0) begin
			r.flat = 1'b1;
			return r;
		end
		for (int k = 0; k < 3; k++) begin
			q = unit_mag(m[k], len2);
			// negate: a positive component comes out negative
			if (c[k] > 0)
				q = -q;
			if (k == 0) r.nx = q;
			else if (k == 1) r.ny = q;
			else r.nz = q;
		end
		return r;
	endfunction

	assign pending = normal_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] v[9];
		normal_t want;
		if (!arst_n) begin
			fail_count <= 0;
			normals_seen <= 0;
			flat_seen <= 0;
		end else begin
			if (tri_valid && tri_ready) begin
				v = '{first_x, first_y, first_z, second_x, second_y, second_z,
					third_x, third_y, third_z};
				normal_q.push_back(face_normal(v));
			end
			if (norm_valid && norm_ready) begin
				normals_seen <= normals_seen + 1;
				if (degenerate)
					flat_seen <= flat_seen + 1;
				if (normal_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: normal word with nothing pending", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					want = normal_q.pop_front();
					if (want.nx !== normal_x || want.ny !== normal_y ||
						want.nz !== normal_z || want.flat !== degenerate) begin
						if (fail_count < 10)
							$display("%0t: expected (%0d %0d %0d deg %0b) got (%0d %0d %0d deg %0b)",
								$realtime, want.nx, want.ny, want.nz, want.flat,
								normal_x, normal_y, normal_z, degenerate);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- test/tb.sv -----
// Testbench top for triangle_unit_normal: stimulus, idling phases, watchdog and verdict.
`timescale 1ns / 100ps
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tri_valid = 1'b0;
	logic tri_ready;
	logic signed [15:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [15:0] second_x = '0, second_y = '0, second_z = '0;
	logic signed [15:0] third_x = '0, third_y = '0, third_z = '0;
	logic norm_valid;
	logic norm_ready = 1'b0;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic degenerate;

	int fail_count, pending, normals_seen, flat_seen;
	int tx_idle = 0;
	int rx_idle = 0;
	int quiet_cycles = 0;
	int tri_sent = 0;

	// watchdog: cycles with no word moving on either channel
	localparam int QUIET_LIMIT = 5000;

	always #4 clk = ~clk;

	triangle_unit_normal i_dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.third_x(third_x), .third_y(third_y), .third_z(third_z),
		.norm_valid(norm_valid), .norm_ready(norm_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	tun_checker i_check (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.third_x(third_x), .third_y(third_y), .third_z(third_z),
		.norm_valid(norm_valid), .norm_ready(norm_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate),
		.fail_count(fail_count), .pending(pending),
		.normals_seen(normals_seen), .flat_seen(flat_seen)
	);

	// receiver: drop ready at random at the falling edge
	always @(negedge clk)
		norm_ready <= arst_n && ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		if ((tri_valid && tri_ready) || (norm_valid && norm_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired with %0d normals pending", pending);
			$display("triangle_unit_normal verification failed");
			$finish;
		end
	end

	// present one triangle word, hold it until accepted; called at a falling edge
	task automatic send_tri(input logic signed [15:0] v[9]);
		if ($urandom_range(99) < tx_idle) begin
			tri_valid = 1'b0;
			while ($urandom_range(99) < tx_idle)
				@(negedge clk);
			@(negedge clk);
		end
		{first_x, first_y, first_z} = {v[0], v[1], v[2]};
		{second_x, second_y, second_z} = {v[3], v[4], v[5]};
		{third_x, third_y, third_z} = {v[6], v[7], v[8]};
		tri_valid = 1'b1;
		do @(posedge clk); while (!tri_ready);
		tri_sent++;
		@(negedge clk);
	endtask

	// pick one coordinate: full range, small, or an extreme
	function automatic logic signed [15:0] pick_coord(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(16))) - 16'sd8;
			default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic random_tri();
		logic signed [15:0] v[9];
		int mode, shape;
		shape = $urandom_range(99);
		mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
		for (int k = 0; k < 9; k++)
			v[k] = pick_coord(mode);
		if (shape < 6) begin
			// repeated vertex
			for (int k = 0; k < 3; k++)
				v[3 + k] = v[k];
		end else if (shape < 12) begin
			// collinear: third vertex mirrors second through the first
			for (int k = 0; k < 3; k++) begin
				v[k] = pick_coord(1);
				v[3 + k] = pick_coord(1);
				v[6 + k] = 16'(2 * v[k] - v[3 + k]);
			end
		end else if (shape < 20) begin
			// flat in one axis plane: normal lies along that axis
			v[3 + shape % 3] = v[shape % 3];
			v[6 + shape % 3] = v[shape % 3];
		end
		send_tri(v);
	endtask

	task automatic wait_drained();
		tri_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic signed [15:0] v[9];
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, repeated and collinear vertices, axis normals
		v = '{default: 16'sh0000}; send_tri(v);
		v = '{default: 16'sh7fff}; send_tri(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000}; send_tri(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh7fff}; send_tri(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000}; send_tri(v);
		v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_tri(v);
		v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; send_tri(v);
		v = '{0, 0, 0, 0, 1, 0, 0, 0, 1}; send_tri(v);
		v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_tri(v);
		v = '{1, 2, 3, 2, 4, 6, 3, 6, 9}; send_tri(v);
		v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh7fff}; send_tri(v);
		v = '{-1, -1, -1, 0, 0, 0, 1, 1, 1}; send_tri(v);
		v = '{0, 0, 0, 1, 1, 0, 1, -1, 0}; send_tri(v);
		v = '{5, 5, 5, 5, 5, 5, 9, 9, 2}; send_tri(v);
		v = '{16'sh8000, 0, 0, 16'sh7fff, 0, 0, 16'sh8000, 16'sh7fff, 16'sh7fff};
		send_tri(v);
		// hold off until every pending normal is out
		wait_drained();

		// random: three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle = (phase == 0) ? 23 : (phase == 1) ? 55 : 0;
			rx_idle = (phase == 0) ? 55 : (phase == 1) ? 23 : 0;
			for (int n = 0; n < 470; n++)
				random_tri();
			wait_drained();
		end

		tri_valid = 1'b0;
		wait_drained();
		repeat (40) @(negedge clk);
		$display("sent %0d triangles, checked %0d normals, %0d of them degenerate",
			tri_sent, normals_seen, flat_seen);
		$display("idling covered sender-heavy, receiver-heavy and back-to-back phases");
		if (fail_count == 0 && pending == 0 && normals_seen == tri_sent)
			$display("triangle_unit_normal verification clean");
		else
			$display("triangle_unit_normal verification failed");
		$finish;
	end
endmodule
